// ===== design/msd_pkg.sv =====
package msd_pkg;

  localparam int CHANNELS_DEFAULT = 32;
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_DATA   = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_CHANNEL = 3'd1;
  localparam logic [2:0] ST_SEQ     = 3'd2;
  localparam logic [2:0] ST_SIZE    = 3'd3;
  localparam logic [2:0] ST_TYPE    = 3'd4;
  localparam logic [2:0] ST_SHORT   = 3'd5;
  localparam logic [2:0] ST_UNKNOWN = 3'd6;

  localparam logic REG_ORDERED    = 1'b0;
  localparam logic REG_TYPE_COUNT = 1'b1;

  localparam logic [15:0] TYPE_COUNT_RESET = 16'h8000;

  typedef enum logic [2:0] {
    PH_CHAN,
    PH_SEQ_LO,
    PH_SEQ_HI,
    PH_SIZE0,
    PH_SIZE1,
    PH_TYPE0,
    PH_TYPE1,
    PH_PAYLOAD
  } phase_t;

  typedef enum logic {
    BEAT_MAIN,
    BEAT_ERR
  } beat_t;

  typedef struct packed {
    logic [7:0] packet_byte;
    logic       end_of_packet;
  } pkt_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [4:0]  channel;
    logic [15:0] sequence_res;
    logic [14:0] payload_size;
    logic [14:0] msg_type;
    logic [7:0]  data_byte;
    logic [2:0]  status;
    logic        last;
  } msg_t;

  // one parsed byte: its first result and an optional trailing error report
  typedef struct packed {
    msg_t       res;
    logic       err;
    logic [2:0] err_status;
  } op_t;

endpackage

// ===== design/message_stream_deframer.sv =====
// message stream deframer
// pkt channel: one packet byte per beat (pkt_valid/pkt_stall), end_of_packet
// marks the final byte of a packet. msg channel: parsed results, one per beat
// (msg_valid/msg_stall): a header beat once the header is complete, one beat
// per payload byte, last set on the final beat of a message; errors give an
// error report beat with last set and close the block until reset.
// a byte is parsed in the cycle it is accepted and its results go into an
// op queue; the output register then loads the first result from the
// queue head. one byte per cycle is taken as long as the queue has
// room; a byte that yields a result plus an error report holds the output
// for two beats, so the queue depth bounds how far input runs ahead.
// when msg_stall is high the output register holds, the queue fills and
// pkt_stall rises once it is full. once closed, bytes are still taken and
// dropped. reset (rst, synchronous) clears the parser, empties the queue and
// restores ordered_channels to 0 and type_count to 32768; no clearing pass.
// registers over apb: ordered_channels at 0x0, type_count at 0x4.
module message_stream_deframer
  import msd_pkg::*;
#(
  parameter int CHANNELS    = CHANNELS_DEFAULT,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        pkt_valid,
  output logic        pkt_stall,
  input  pkt_t        pkt,
  output logic        msg_valid,
  input  logic        msg_stall,
  output msg_t        msg,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [CHANNELS-1:0] ordered;
  logic [15:0]         type_count;
  logic                accept;
  logic                push;
  logic                pop;
  logic                empty;
  logic                full;
  op_t                 wr_op;
  op_t                 head;

  assign pready    = 1'b1;
  assign pkt_stall = full;
  assign accept    = pkt_valid && !pkt_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      ordered    <= '0;
      type_count <= TYPE_COUNT_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        REG_ORDERED:    ordered    <= pwdata[CHANNELS-1:0];
        REG_TYPE_COUNT: type_count <= pwdata[15:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_ORDERED:    prdata = 32'(ordered);
      REG_TYPE_COUNT: prdata = {16'h0000, type_count};
    endcase
  end

  msd_front #(
    .CHANNELS(CHANNELS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .pkt       (pkt),
    .ordered   (ordered),
    .type_count(type_count),
    .push      (push),
    .op        (wr_op)
  );

  msd_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .wr_op(wr_op),
    .pop  (pop),
    .head (head),
    .empty(empty),
    .full (full)
  );

  msd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .empty    (empty),
    .pop      (pop),
    .msg_valid(msg_valid),
    .msg_stall(msg_stall),
    .msg      (msg)
  );

endmodule

// ===== design/msd_front.sv =====
module msd_front
  import msd_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  pkt_t                pkt,
  input  logic [CHANNELS-1:0] ordered,
  input  logic [15:0]         type_count,
  output logic                push,
  output op_t                 op
);

  phase_t      phase, phase_next;
  logic [4:0]  chan, chan_next;
  logic [15:0] seq, seq_next;
  logic [14:0] size, size_next;
  logic [14:0] typ, typ_next;
  logic [14:0] left, left_next;
  logic [6:0]  high, high_next;
  logic        closed, closed_next;
  logic        produce;
  logic [7:0]  b;
  logic        eop;
  logic [31:0] ord_ext;
  logic        bad_chan;
  logic        chan_ordered;
  logic [14:0] left_dec;

  assign b            = pkt.packet_byte;
  assign eop          = pkt.end_of_packet;
  assign ord_ext      = 32'(ordered);
  assign bad_chan     = b >= 8'(CHANNELS);
  assign chan_ordered = ord_ext[b[4:0]];
  assign left_dec     = left - 15'd1;

  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_CHAN: begin
        if (!bad_chan) phase_next = chan_ordered ? PH_SEQ_LO : PH_SIZE0;
      end
      PH_SEQ_LO: phase_next = PH_SEQ_HI;
      PH_SEQ_HI: phase_next = PH_SIZE0;
      PH_SIZE0:  phase_next = b[7] ? PH_SIZE1 : PH_TYPE0;
      PH_SIZE1:  phase_next = PH_TYPE0;
      PH_TYPE0: begin
        if (b[7]) phase_next = PH_TYPE1;
        else      phase_next = (size == '0) ? PH_CHAN : PH_PAYLOAD;
      end
      PH_TYPE1:   phase_next = (size == '0) ? PH_CHAN : PH_PAYLOAD;
      PH_PAYLOAD: phase_next = (left_dec == '0) ? PH_CHAN : PH_PAYLOAD;
    endcase
  end

  always_comb begin
    logic       fail0;
    logic       header_done;
    logic       fin;
    logic [2:0] fail_status;
    chan_next   = chan;
    seq_next    = seq;
    size_next   = size;
    typ_next    = typ;
    left_next   = left;
    high_next   = high;
    closed_next = closed;
    fail0       = 1'b0;
    fail_status = ST_OK;
    header_done = 1'b0;
    fin         = 1'b0;
    produce     = 1'b0;
    op          = '0;
    unique case (phase)
      PH_CHAN: begin
        chan_next = '0;
        seq_next  = '0;
        size_next = '0;
        typ_next  = '0;
        left_next = '0;
        high_next = '0;
        if (bad_chan) begin
          fail0       = 1'b1;
          fail_status = ST_CHANNEL;
        end else begin
          chan_next   = b[4:0];
          fail0       = eop;
          fail_status = chan_ordered ? ST_SEQ : ST_SIZE;
        end
      end
      PH_SEQ_LO: begin
        seq_next    = {8'h00, b};
        fail0       = eop;
        fail_status = ST_SEQ;
      end
      PH_SEQ_HI: begin
        seq_next    = {b, seq[7:0]};
        fail0       = eop;
        fail_status = ST_SIZE;
      end
      PH_SIZE0: begin
        fail0 = eop;
        if (b[7]) begin
          high_next   = b[6:0];
          fail_status = ST_SIZE;
        end else begin
          size_next   = {7'h00, b};
          fail_status = ST_TYPE;
        end
      end
      PH_SIZE1: begin
        size_next   = {high, b};
        fail0       = eop;
        fail_status = ST_TYPE;
      end
      PH_TYPE0: begin
        if (b[7]) begin
          high_next   = b[6:0];
          fail0       = eop;
          fail_status = ST_TYPE;
        end else begin
          typ_next    = {7'h00, b};
          header_done = 1'b1;
        end
      end
      PH_TYPE1: begin
        typ_next    = {high, b};
        header_done = 1'b1;
      end
      PH_PAYLOAD: begin
        left_next = left_dec;
        fin       = left_dec == '0;
      end
    endcase

    op.res.channel      = chan_next;
    op.res.sequence_res = seq_next;
    op.res.payload_size = size_next;
    op.res.msg_type     = typ_next;

    if (fail0) begin
      produce       = 1'b1;
      op.res.kind   = KIND_ERROR;
      op.res.status = fail_status;
      op.res.last   = 1'b1;
      closed_next   = 1'b1;
    end else if (header_done || phase == PH_PAYLOAD) begin
      produce          = 1'b1;
      op.res.kind      = header_done ? KIND_HEADER : KIND_DATA;
      op.res.data_byte = header_done ? 8'h00 : b;
      if (header_done && size == '0) fin = 1'b1;
      if (header_done && !fin) left_next = size;
      if (fin) begin
        // type check only once the whole message is in
        if ({1'b0, typ_next} >= type_count) begin
          op.err        = 1'b1;
          op.err_status = ST_UNKNOWN;
          closed_next   = 1'b1;
        end else begin
          op.res.last = 1'b1;
        end
      end else if (eop) begin
        op.err        = 1'b1;
        op.err_status = ST_SHORT;
        closed_next   = 1'b1;
      end
    end
  end

  assign push = accept && !closed && produce;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_CHAN;
      chan   <= '0;
      seq    <= '0;
      size   <= '0;
      typ    <= '0;
      left   <= '0;
      high   <= '0;
      closed <= 1'b0;
    end else if (accept && !closed) begin
      phase  <= phase_next;
      chan   <= chan_next;
      seq    <= seq_next;
      size   <= size_next;
      typ    <= typ_next;
      left   <= left_next;
      high   <= high_next;
      closed <= closed_next;
    end
  end

  a_closed_sticks: assert property (@(posedge clk) disable iff (rst)
    closed |=> closed)
    else $error("deframer reopened without reset");

  a_no_push_closed: assert property (@(posedge clk) disable iff (rst)
    closed |-> !push)
    else $error("result queued after close");

  a_err_closes: assert property (@(posedge clk) disable iff (rst)
    (push && (op.err || op.res.kind == KIND_ERROR)) |=> closed)
    else $error("error report did not close the deframer");

endmodule

// ===== design/msd_queue.sv =====
module msd_queue
  import msd_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  op_t  wr_op,
  input  logic pop,
  output op_t  head,
  output logic empty,
  output logic full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  op_t           entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign empty = count == '0;
  assign full  = count == CW'(DEPTH);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= wr_op;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      if (pop)  rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      if (push && !pop)      count <= count + CW'(1);
      else if (pop && !push) count <= count - CW'(1);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    empty |-> !pop)
    else $error("queue underflow");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue count out of range");

endmodule

// ===== design/msd_back.sv =====
module msd_back
  import msd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  op_t  head,
  input  logic empty,
  output logic pop,
  output logic msg_valid,
  input  logic msg_stall,
  output msg_t msg
);

  beat_t state, state_next;
  logic  load;
  logic  take;
  msg_t  beat;

  assign load = !msg_valid || !msg_stall;
  assign take = load && !empty;

  always_comb begin
    state_next = state;
    unique case (state)
      BEAT_MAIN: if (take && head.err) state_next = BEAT_ERR;
      BEAT_ERR:  if (take) state_next = BEAT_MAIN;
    endcase
  end

  always_comb begin
    beat = head.res;
    pop  = 1'b0;
    unique case (state)
      BEAT_MAIN: pop = take && !head.err;
      BEAT_ERR: begin
        beat.kind      = KIND_ERROR;
        beat.data_byte = '0;
        beat.status    = head.err_status;
        beat.last      = 1'b1;
        pop            = take;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BEAT_MAIN;
      msg_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) msg_valid <= !empty;
    end
  end

  always_ff @(posedge clk) begin
    if (take) msg <= beat;
  end

  a_err_beat_pending: assert property (@(posedge clk) disable iff (rst)
    (state == BEAT_ERR) |-> (!empty && head.err && msg_valid))
    else $error("error beat without its queue entry");

  a_err_follows_main: assert property (@(posedge clk) disable iff (rst)
    $rose(state == BEAT_ERR) |-> (msg.last == 1'b0 || msg.kind == KIND_ERROR))
    else $error("error beat after a final beat");

endmodule
